// File: rtl/nearest_acceptable_base_search_macros.svh
// Assertion helpers shared by the search RTL.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef NEAREST_ACCEPTABLE_BASE_SEARCH_MACROS_SVH
`define NEAREST_ACCEPTABLE_BASE_SEARCH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NABS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NABS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nabs_pkg.sv
`default_nettype none

package nabs_pkg;

    localparam int unsigned TEAM_COUNT = 8;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_SPARE = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        ST_STORED     = 3'd0,
        ST_IGNORED    = 3'd1,
        ST_FULL       = 3'd2,
        ST_BASED      = 3'd3,
        ST_EXACT      = 3'd4,
        ST_NEAREST    = 3'd5,
        ST_UNRESOLVED = 3'd6
    } t_status;

    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic [2:0]         owner;
        logic [31:0]        id;
    } t_site;

    typedef struct packed {
        logic clear;   // start of a query: drop pipeline and best
        logic take;    // site at the ring head is a live entry
    } t_scan_ctl;

    typedef struct packed {
        logic        have_exact;
        logic [31:0] exact_id;
        logic        have_near;
        logic [31:0] near_id;
    } t_scan_res;

    // Owner acceptable to team: same team, or the matrix bit for the pair.
    function automatic logic owner_ok(input logic [2:0] team, input logic [2:0] owner,
                                      input logic [63:0] matrix);
        logic in_range;
        in_range = (32'(team) < TEAM_COUNT) && (32'(owner) < TEAM_COUNT);
        return (team == owner) || (in_range && matrix[{team, owner}]);
    endfunction

endpackage

`default_nettype wire

// File: rtl/nabs_cell.sv
`default_nettype none

module nabs_cell (
    input  wire logic           i_clk,
    input  wire logic           i_load,
    input  wire nabs_pkg::t_site i_load_site,
    input  wire logic           i_shift,
    input  wire nabs_pkg::t_site i_next_site,
    output nabs_pkg::t_site      o_site
);
    import nabs_pkg::*;

    t_site r_site;

    // Load takes the new site; shift takes the neighbour's site.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_site <= i_load_site;
        end else if (i_shift) begin
            r_site <= i_next_site;
        end
    end

    assign o_site = r_site;

endmodule

`default_nettype wire

// File: rtl/nabs_eval.sv
`default_nettype none

module nabs_eval (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire nabs_pkg::t_scan_ctl i_ctl,
    input  wire nabs_pkg::t_site     i_site,
    input  wire logic signed [15:0] i_qx,
    input  wire logic signed [15:0] i_qy,
    input  wire logic [2:0]         i_team,
    input  wire logic [63:0]        i_matrix,
    output nabs_pkg::t_scan_res      o_res
);
    import nabs_pkg::*;

    `include "nearest_acceptable_base_search_macros.svh"

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] px;
    logic signed [33:0] py;
    logic [32:0]        d2;

    // first stage: squares of the offsets, owner and exact-match flags
    logic        r_a_valid;
    logic        r_a_ok;
    logic        r_a_exact;
    logic [31:0] r_a_id;
    logic [31:0] r_a_sqx;
    logic [31:0] r_a_sqy;

    // second stage: running best
    logic        r_have_exact;
    logic [31:0] r_exact_id;
    logic        r_have_near;
    logic [31:0] r_near_id;
    logic [32:0] r_best;

    always_comb begin
        dx = 17'(i_site.x) - 17'(i_qx);
        dy = 17'(i_site.y) - 17'(i_qy);
        px = 34'(dx) * 34'(dx);
        py = 34'(dy) * 34'(dy);
        d2 = {1'b0, r_a_sqx} + {1'b0, r_a_sqy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_have_exact <= 1'b0;
            r_have_near  <= 1'b0;
        end else if (i_ctl.clear) begin
            r_a_valid    <= 1'b0;
            r_have_exact <= 1'b0;
            r_have_near  <= 1'b0;
        end else begin
            r_a_valid <= i_ctl.take;
            r_a_ok    <= owner_ok(i_team, i_site.owner, i_matrix);
            r_a_exact <= (i_site.x == i_qx) && (i_site.y == i_qy);
            r_a_id    <= i_site.id;
            r_a_sqx   <= px[31:0];
            r_a_sqy   <= py[31:0];
            if (r_a_valid && r_a_ok) begin
                if (!r_have_exact && r_a_exact) begin
                    r_have_exact <= 1'b1;
                    r_exact_id   <= r_a_id;
                end
                // strict less-than keeps the earliest site on a tie
                if (!r_have_near || (d2 < r_best)) begin
                    r_have_near <= 1'b1;
                    r_best      <= d2;
                    r_near_id   <= r_a_id;
                end
            end
        end
    end

    assign o_res = '{have_exact: r_have_exact, exact_id: r_exact_id,
                     have_near: r_have_near, near_id: r_near_id};

    `NABS_ASSERT_NOW(a_exact_implies_near, r_have_exact, r_have_near,
        "exact match recorded without a nearest candidate")
    `NABS_ASSERT_NEXT(a_clear_drops_best, i_ctl.clear, !r_have_near && !r_a_valid,
        "query start did not drop the running best")
    `NABS_ASSERT_NEXT(a_stage_from_take, !i_ctl.take, !r_a_valid,
        "first stage valid without a live site")

endmodule

`default_nettype wire

// File: rtl/nearest_acceptable_base_search.sv
// Nearest acceptable base search.
// Input channel (i_in_valid / o_in_stall) carries one command word: load a
// site, query an assignment, or clear the table. Every word gives exactly one
// result word on the output channel (o_out_valid / i_out_stall).
// Loads, clears, spare commands and queries that already hold a base finish
// in the cycle they are taken; the result is visible in the next cycle.
// A searching query rotates the site ring once round its MAX_SITES cells,
// one site per cycle through a two-stage square/compare unit, then steps
// through the flush and finish states; an output stall holds it in finish.
// One word is worked on at a time: short words may follow every cycle when the
// output is free; a searching query admits the next word once back in idle.
// A result is held in the output register until taken; while it is held and
// stalled, a new word is only taken once the register frees up, and a
// finished search waits in its last state.
// The acceptance matrix is written through i_cfg_wr_en / i_cfg_wr_data.
// Reset empties the table and clears the matrix; site cells are not cleared,
// only entries below the fill count are ever used.
`default_nettype none

module nearest_acceptable_base_search #(
    parameter int unsigned MAX_SITES = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [63:0]        i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic signed [15:0] i_x_coord,
    input  wire logic signed [15:0] i_y_coord,
    input  wire logic [2:0]         i_team,
    input  wire logic [7:0]         i_site_kind,
    input  wire logic [31:0]        i_new_base_id,
    input  wire logic [31:0]        i_current_base_id,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [31:0]             o_base_id,
    output logic [2:0]              o_status
);
    import nabs_pkg::*;

    `include "nearest_acceptable_base_search_macros.svh"

    localparam int unsigned CW = $clog2(MAX_SITES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_FINISH
    } t_state;

    t_state      r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_step;
    logic [63:0] r_accept_matrix;
    logic signed [15:0] r_qx;
    logic signed [15:0] r_qy;
    logic [2:0]  r_qteam;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_base_id;
    logic [2:0]  r_status;

    logic        out_free;
    logic        in_accept;
    logic        capable;
    logic        load_wr;
    logic        shift;
    t_site       new_site;
    t_site       cell_q [MAX_SITES];
    t_scan_ctl   scan_ctl;
    t_scan_res   scan_res;

    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        in_accept = i_in_valid && !o_in_stall;
        capable   = ((i_site_kind == 8'd1) || (i_site_kind == 8'd2) ||
                     (i_site_kind == 8'd3)) && (i_new_base_id != 32'd0);
        load_wr   = in_accept && (t_command'(i_command) == CMD_LOAD) && capable &&
                    (32'(r_count) < MAX_SITES);
        shift     = (r_state == S_SCAN);
        new_site  = '{y: i_y_coord, x: i_x_coord, owner: i_team, id: i_new_base_id};
        scan_ctl.clear = in_accept && (t_command'(i_command) == CMD_QUERY) &&
                         (i_current_base_id == 32'd0);
        scan_ctl.take  = shift && (r_step < r_count);
        // drop a result word once the receiver takes it; raise it for a short
        // word taken now or for a finished search
        n_out_valid = r_out_valid && i_out_stall;
        if ((r_state == S_IDLE) && in_accept && !scan_ctl.clear) begin
            n_out_valid = 1'b1;
        end
        if ((r_state == S_FINISH) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_in_stall = !((r_state == S_IDLE) && out_free);

    // Ring of site cells: cell g hands its site to cell g-1 each scan cycle,
    // the head cell wraps round to the tail. A full turn restores load order.
    for (genvar g = 0; g < MAX_SITES; g++) begin : g_cell
        nabs_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (load_wr && (r_count == CW'(g))),
            .i_load_site (new_site),
            .i_shift     (shift),
            .i_next_site (cell_q[(g + 1) % MAX_SITES]),
            .o_site      (cell_q[g])
        );
    end

    nabs_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (scan_ctl),
        .i_site   (cell_q[0]),
        .i_qx     (r_qx),
        .i_qy     (r_qy),
        .i_team   (r_qteam),
        .i_matrix (r_accept_matrix),
        .o_res    (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_step          <= '0;
            r_accept_matrix <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_accept_matrix <= i_cfg_wr_data;
            end
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        unique case (t_command'(i_command))
                            CMD_LOAD: begin
                                r_base_id <= 32'd0;
                                if (!capable) begin
                                    r_status <= ST_IGNORED;
                                end else if (load_wr) begin
                                    r_count  <= r_count + CW'(1);
                                    r_status <= ST_STORED;
                                end else begin
                                    r_status <= ST_FULL;
                                end
                            end
                            CMD_QUERY: begin
                                if (i_current_base_id != 32'd0) begin
                                    r_base_id <= i_current_base_id;
                                    r_status  <= ST_BASED;
                                end else begin
                                    // hold the query and start a full ring turn
                                    r_qx    <= i_x_coord;
                                    r_qy    <= i_y_coord;
                                    r_qteam <= i_team;
                                    r_step  <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_CLEAR: begin
                                r_base_id <= 32'd0;
                                r_count   <= '0;
                                r_status  <= ST_STORED;
                            end
                            default: begin
                                r_base_id <= 32'd0;
                                r_status  <= ST_IGNORED;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + CW'(1);
                    if (r_step == CW'(MAX_SITES - 1)) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    // last site passes the compare stage
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        priority if (scan_res.have_exact) begin
                            r_base_id <= scan_res.exact_id;
                            r_status  <= ST_EXACT;
                        end else if (scan_res.have_near) begin
                            r_base_id <= scan_res.near_id;
                            r_status  <= ST_NEAREST;
                        end else begin
                            r_base_id <= 32'd0;
                            r_status  <= ST_UNRESOLVED;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_base_id   = r_base_id;
    assign o_status    = r_status;

    `NABS_ASSERT_NOW(a_count_bound, 1'b1, 32'(r_count) <= MAX_SITES,
        "site count beyond table size")
    `NABS_ASSERT_NEXT(a_count_stable_scan, r_state == S_SCAN, $stable(r_count),
        "site count changed during a ring turn")
    `NABS_ASSERT_NEXT(a_finish_delivers, (r_state == S_FINISH) && out_free,
        r_out_valid && (r_state == S_IDLE), "finished search did not deliver its word")
    `NABS_ASSERT_NEXT(a_query_no_early_word, scan_ctl.clear, !r_out_valid,
        "searching query produced a word at once")

endmodule

`default_nettype wire

// File: test/nearest_acceptable_base_search_test.sv
`timescale 1ns / 1ps

localparam int unsigned SITE_CAPACITY = 256;
localparam logic [7:0] CAPABLE_TYPE_LO = 8'd1;
localparam logic [7:0] CAPABLE_TYPE_HI = 8'd3;

typedef struct {
    nabs_pkg::t_command cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [2:0]         team;
    logic [7:0]         otype;
    logic [31:0]        new_id;
    logic [31:0]        cur_id;
} t_order_word;

typedef struct {
    logic [31:0]       id;
    nabs_pkg::t_status status;
} t_assignment;

// Mirror of the site table and the acceptance matrix; holds the assignments still owed.
class base_assignment_board;
    localparam int unsigned REPORT_LIMIT = 200;

    logic [63:0]        accept_bits;
    logic signed [15:0] site_x [SITE_CAPACITY];
    logic signed [15:0] site_y [SITE_CAPACITY];
    logic [2:0]         site_owner [SITE_CAPACITY];
    logic [31:0]        site_id [SITE_CAPACITY];
    int unsigned        site_total;
    t_assignment        pending_assignments [$];
    int unsigned        mismatches;

    function new();
        accept_bits = '0;
        site_total  = 0;
        mismatches  = 0;
    endfunction

    function void set_matrix(input logic [63:0] bits);
        accept_bits = bits;
    endfunction

    function bit acceptable(input logic [2:0] team, input logic [2:0] owner);
        return (owner == team) || accept_bits[8 * int'(team) + int'(owner)];
    endfunction

    // Apply one word to the table and work out the assignment it yields.
    function t_assignment predict_assignment(input t_order_word w);
        t_assignment a;
        bit          have_exact;
        bit          have_near;
        logic [31:0] exact_id;
        logic [31:0] near_id;
        longint      best;
        longint      dx;
        longint      dy;
        longint      d2;
        int unsigned i;
        a.id       = '0;
        a.status   = nabs_pkg::ST_IGNORED;
        have_exact = 1'b0;
        have_near  = 1'b0;
        exact_id   = '0;
        near_id    = '0;
        best       = 0;
        case (w.cmd)
            nabs_pkg::CMD_LOAD: begin
                if (w.otype >= CAPABLE_TYPE_LO && w.otype <= CAPABLE_TYPE_HI
                        && w.new_id != '0) begin
                    if (site_total >= SITE_CAPACITY) begin
                        a.status = nabs_pkg::ST_FULL;
                    end else begin
                        site_x[site_total]     = w.x;
                        site_y[site_total]     = w.y;
                        site_owner[site_total] = w.team;
                        site_id[site_total]    = w.new_id;
                        site_total++;
                        a.status = nabs_pkg::ST_STORED;
                    end
                end
            end
            nabs_pkg::CMD_QUERY: begin
                if (w.cur_id != '0) begin
                    a.id     = w.cur_id;
                    a.status = nabs_pkg::ST_BASED;
                end else begin
                    for (i = 0; i < site_total; i++) begin
                        if (acceptable(w.team, site_owner[i])) begin
                            if (!have_exact && site_x[i] == w.x && site_y[i] == w.y) begin
                                have_exact = 1'b1;
                                exact_id   = site_id[i];
                            end
                            dx = longint'(site_x[i]) - longint'(w.x);
                            dy = longint'(site_y[i]) - longint'(w.y);
                            d2 = dx * dx + dy * dy;
                            // strict compare: the earliest site keeps a tie
                            if (!have_near || d2 < best) begin
                                have_near = 1'b1;
                                best      = d2;
                                near_id   = site_id[i];
                            end
                        end
                    end
                    if (have_exact) begin
                        a.id     = exact_id;
                        a.status = nabs_pkg::ST_EXACT;
                    end else if (have_near) begin
                        a.id     = near_id;
                        a.status = nabs_pkg::ST_NEAREST;
                    end else begin
                        a.status = nabs_pkg::ST_UNRESOLVED;
                    end
                end
            end
            nabs_pkg::CMD_CLEAR: begin
                site_total = 0;
                a.status   = nabs_pkg::ST_STORED;
            end
            default: begin
            end
        endcase
        return a;
    endfunction

    function void note_word(input t_order_word w);
        pending_assignments = {pending_assignments, predict_assignment(w)};
    endfunction

    function int unsigned pending();
        return pending_assignments.size();
    endfunction

    function void check_result(input logic [31:0] id, input logic [2:0] status);
        t_assignment want;
        if (pending_assignments.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: result with none pending: expected nothing, got id %h status %0d",
                         $time, id, status);
            return;
        end
        want = pending_assignments.pop_front();
        if (id !== want.id) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: base_id mismatch: expected %h, got %h", $time, want.id, id);
        end
        if (status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, status);
        end
    endfunction
endclass

module nearest_acceptable_base_search_test;

    // Slowest run: every word a full ring scan plus long random gaps and stalls,
    // then taken several times over.
    localparam int unsigned CYCLE_LIMIT     = 2_000_000;
    localparam int unsigned HOLD_OFF_CYCLES = 1500;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [63:0]        cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         command = '0;
    logic signed [15:0] x_coord = '0;
    logic signed [15:0] y_coord = '0;
    logic [2:0]         team = '0;
    logic [7:0]         site_kind = '0;
    logic [31:0]        new_base_id = '0;
    logic [31:0]        current_base_id = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [31:0]        base_id;
    logic [2:0]         status;

    int unsigned        sender_idle_pct = 0;
    int unsigned        stall_pct = 0;
    bit                 hold_off_req = 1'b0;
    int unsigned        words_sent = 0;
    int unsigned        cycle_count = 0;

    base_assignment_board board = new();

    nearest_acceptable_base_search #(
        .MAX_SITES(SITE_CAPACITY)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_command        (command),
        .i_x_coord        (x_coord),
        .i_y_coord        (y_coord),
        .i_team           (team),
        .i_site_kind      (site_kind),
        .i_new_base_id    (new_base_id),
        .i_current_base_id(current_base_id),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_base_id        (base_id),
        .o_status         (status)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog: stop a hung run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: take a result word at each edge where valid is high and stall low,
    // then pick the stall for the next cycle. A hold-off request keeps stall high
    // for a long stretch so the block backs up into its input.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result(base_id, status);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic t_order_word mk(input nabs_pkg::t_command cmd,
                                       input logic signed [15:0] x,
                                       input logic signed [15:0] y,
                                       input logic [2:0] tm,
                                       input logic [7:0] otype,
                                       input logic [31:0] new_id,
                                       input logic [31:0] cur_id);
        t_order_word w;
        w.cmd    = cmd;
        w.x      = x;
        w.y      = y;
        w.team   = tm;
        w.otype  = otype;
        w.new_id = new_id;
        w.cur_id = cur_id;
        return w;
    endfunction

    // Fill every field at random; callers then fix what the command uses.
    function automatic t_order_word random_word(input nabs_pkg::t_command cmd);
        return mk(cmd, 16'($urandom), 16'($urandom), 3'($urandom), 8'($urandom),
                  $urandom, $urandom);
    endfunction

    function automatic logic signed [15:0] jitter(input logic signed [15:0] c);
        return 16'(int'(c) + int'($urandom_range(8)) - 4);
    endfunction

    // Offer one word, idling first at the sender's rate; hold the payload until taken.
    task automatic send_word(input t_order_word w);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= w.cmd;
        x_coord         <= w.x;
        y_coord         <= w.y;
        team            <= w.team;
        site_kind       <= w.otype;
        new_base_id     <= w.new_id;
        current_base_id <= w.cur_id;
        do @(posedge clk); while (in_stall);
        board.note_word(w);
        words_sent++;
    endtask

    // Drop valid and wait for every owed result; the block is then idle.
    task automatic close_phase();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic write_matrix(input logic [63:0] bits);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bits;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_matrix(bits);
    endtask

    // Directed words: field extremes, rejected loads, the spare command, exact hits,
    // distance ties, a query that already holds a base, the widest distance and clear.
    // Matrix in force: team 0 accepts owner 1, team 7 accepts owner 0.
    task automatic run_directed();
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sd0, 16'sd0, 3'd0, 8'd0, 32'd0, 32'd0));
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sd5, -16'sd5, 3'd3, 8'd0, 32'd0,
                     32'hFFFF_FFFF));
        send_word(mk(nabs_pkg::CMD_LOAD, 16'sd1, 16'sd1, 3'd0, 8'd0, 32'd5, 32'd0));
        send_word(mk(nabs_pkg::CMD_LOAD, 16'sd1, 16'sd1, 3'd0, 8'd4, 32'd5, 32'd0));
        send_word(mk(nabs_pkg::CMD_LOAD, 16'sd1, 16'sd1, 3'd0, 8'hFF, 32'd5, 32'd0));
        send_word(mk(nabs_pkg::CMD_LOAD, 16'sd1, 16'sd1, 3'd0, CAPABLE_TYPE_LO, 32'd0,
                     32'd0));
        send_word(mk(nabs_pkg::CMD_SPARE, 16'sd1, 16'sd1, 3'd0, CAPABLE_TYPE_LO, 32'd9,
                     32'd0));
        send_word(mk(nabs_pkg::CMD_LOAD, 16'sh8000, 16'sh8000, 3'd0, CAPABLE_TYPE_LO,
                     32'hFFFF_FFFF, 32'd0));
        send_word(mk(nabs_pkg::CMD_LOAD, 16'sh7FFF, 16'sh7FFF, 3'd1, 8'd2, 32'd1, 32'd0));
        send_word(mk(nabs_pkg::CMD_LOAD, 16'sd0, 16'sd0, 3'd2, CAPABLE_TYPE_HI,
                     32'h8000_0000, 32'd0));
        send_word(mk(nabs_pkg::CMD_LOAD, 16'sd3, 16'sd4, 3'd7, 8'd2, 32'h1234, 32'd0));
        send_word(mk(nabs_pkg::CMD_LOAD, -16'sd3, -16'sd4, 3'd7, CAPABLE_TYPE_HI,
                     32'h5678, 32'd0));
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sh7FFF, 16'sh7FFF, 3'd0, 8'd0, 32'd0, 32'd0));
        // equal distance to both corner sites: the earlier one wins
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sh8000, 16'sh7FFF, 3'd0, 8'd0, 32'd0, 32'd0));
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sd0, 16'sd0, 3'd7, 8'd0, 32'd0, 32'd0));
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sd0, 16'sd0, 3'd2, 8'd0, 32'd0, 32'd0));
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sd100, 16'sd100, 3'd5, 8'd0, 32'd0, 32'd0));
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sh8000, 16'sh8000, 3'd7, 8'd0, 32'd0, 32'd0));
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sh8000, 16'sh8000, 3'd3, 8'd0, 32'd0, 32'd1));
        send_word(mk(nabs_pkg::CMD_CLEAR, 16'sd0, 16'sd0, 3'd0, 8'd0, 32'd0, 32'd0));
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sd3, 16'sd4, 3'd7, 8'd0, 32'd0, 32'd0));
        send_word(mk(nabs_pkg::CMD_LOAD, 16'sh7FFF, 16'sh8000, 3'd4, CAPABLE_TYPE_LO,
                     32'h0BAD_CAFE, 32'd0));
        // opposite corner: widest squared distance the grid allows
        send_word(mk(nabs_pkg::CMD_QUERY, 16'sh8000, 16'sh7FFF, 3'd4, 8'd0, 32'd0, 32'd0));
    endtask

    // Load past capacity so the last loads bounce, then scan the full table.
    task automatic fill_table();
        t_order_word w;
        send_word(random_word(nabs_pkg::CMD_CLEAR));
        repeat (SITE_CAPACITY + 4) begin
            w        = random_word(nabs_pkg::CMD_LOAD);
            w.otype  = 8'($urandom_range(CAPABLE_TYPE_HI, CAPABLE_TYPE_LO));
            w.new_id = $urandom | 32'd1;
            send_word(w);
        end
        repeat (4) begin
            w        = random_word(nabs_pkg::CMD_QUERY);
            w.cur_id = '0;
            send_word(w);
        end
        send_word(random_word(nabs_pkg::CMD_CLEAR));
    endtask

    // One episode: maybe clear, load a cluster of sites round a centre, then query
    // on and around them. Tight clusters give exact hits and distance ties; a few
    // rejected loads, spare commands and based queries are mixed in as noise.
    task automatic run_episode(input int unsigned max_loads);
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] hot_x [$];
        logic signed [15:0] hot_y [$];
        int unsigned        n_loads;
        int unsigned        n_queries;
        int unsigned        pick;
        t_order_word        w;
        case ($urandom_range(3))
            0: begin
                cx = 16'sh7FFD;
                cy = 16'sh8002;
            end
            1: begin
                cx = 16'sd0;
                cy = 16'sd0;
            end
            default: begin
                cx = 16'($urandom);
                cy = 16'($urandom);
            end
        endcase
        if ($urandom_range(2) == 0) send_word(random_word(nabs_pkg::CMD_CLEAR));
        n_loads = $urandom_range(max_loads, 1);
        repeat (n_loads) begin
            w        = random_word(nabs_pkg::CMD_LOAD);
            w.otype  = 8'($urandom_range(CAPABLE_TYPE_HI, CAPABLE_TYPE_LO));
            w.new_id = $urandom | 32'd1;
            pick     = $urandom_range(99);
            if (pick < 70) begin
                w.x = jitter(cx);
                w.y = jitter(cy);
            end else if (pick < 85 && hot_x.size() != 0) begin
                pick = $urandom_range(hot_x.size() - 1);
                w.x  = hot_x[pick];
                w.y  = hot_y[pick];
            end
            if ($urandom_range(99) < 12) begin
                if ($urandom_range(1) == 0)
                    w.new_id = '0;
                else if ($urandom_range(3) == 0)
                    w.otype = 8'd0;
                else
                    w.otype = 8'($urandom_range(255, CAPABLE_TYPE_HI + 1));
            end else begin
                hot_x = {hot_x, w.x};
                hot_y = {hot_y, w.y};
            end
            send_word(w);
        end
        if ($urandom_range(19) == 0) send_word(random_word(nabs_pkg::CMD_SPARE));
        n_queries = $urandom_range(6, 1);
        repeat (n_queries) begin
            w    = random_word(nabs_pkg::CMD_QUERY);
            pick = $urandom_range(99);
            if (pick < 40 && hot_x.size() != 0) begin
                pick = $urandom_range(hot_x.size() - 1);
                w.x  = hot_x[pick];
                w.y  = hot_y[pick];
            end else if (pick < 80) begin
                w.x = jitter(cx);
                w.y = jitter(cy);
            end
            if ($urandom_range(99) >= 15) w.cur_id = '0;
            send_word(w);
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words, no idling.
        write_matrix(64'h0100_0000_0000_0002);
        run_directed();
        close_phase();

        // No idling, every pair accepted; overfill the table once.
        write_matrix('1);
        fill_table();
        while (words_sent < 400) run_episode(12);
        close_phase();

        // Sender idle most cycles; only own-team sites acceptable.
        sender_idle_pct = 76;
        write_matrix('0);
        while (words_sent < 580) run_episode(12);
        close_phase();

        // Receiver stalling most cycles; open with a long hold-off while the
        // sender keeps offering words, so the block backs up and stalls its input.
        sender_idle_pct = 0;
        stall_pct       = 76;
        write_matrix({$urandom, $urandom});
        hold_off_req = 1'b1;
        while (words_sent < 760) run_episode(12);
        close_phase();

        // Both sides idling now and then.
        sender_idle_pct = 21;
        stall_pct       = 21;
        write_matrix({$urandom, $urandom} & {$urandom, $urandom});
        while (words_sent < 950) run_episode(16);
        close_phase();

        // Allow one more full scan for any stray result word.
        repeat (SITE_CAPACITY + 16) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/nabs_pkg.sv
rtl/nabs_cell.sv
rtl/nabs_eval.sv
rtl/nearest_acceptable_base_search.sv
test/nearest_acceptable_base_search_test.sv
